@@ hdl/ltoa_pkg.sv @@
// ----------------------------------------------------------------------------
// ltoa_pkg
// Shared types and constants for the LoRa time-on-air unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ltoa_pkg;

   localparam int unsigned SF_W   = 4;
   localparam int unsigned BW_W   = 19;
   localparam int unsigned CR_W   = 3;
   localparam int unsigned PRE_W  = 16;
   localparam int unsigned PL_W   = 8;
   localparam int unsigned IDX_W  = 3;
   localparam int unsigned DATA_W = 19;
   localparam int unsigned OUT_W  = 32;

   // symbol time division: (1e6 << sf) / bw
   localparam int unsigned WQ_W   = 35;
   localparam int unsigned WA_W   = BW_W;
   // block count division: ceil(num / den)
   localparam int unsigned NQ_W   = 12;
   localparam int unsigned NA_W   = 6;
   localparam int unsigned NCELLS = WQ_W;

   localparam int unsigned PSYM_W = 16;
   localparam int unsigned M_W    = 20;
   localparam int unsigned PROD_W = WQ_W + M_W;

   localparam logic [WQ_W-1:0]  US_PER_SECOND = WQ_W'(1000000);
   localparam logic [BW_W-1:0]  LDRO_BW_LIMIT = BW_W'(125000);
   localparam logic [SF_W-1:0]  LDRO_SF_MIN   = SF_W'(11);
   localparam logic [13:0]      NUM_OFFSET    = 14'd28;
   localparam logic [13:0]      CRC_BITS      = 14'd16;
   localparam logic [13:0]      IMPL_PENALTY  = 14'd20;
   localparam logic [M_W-1:0]   PRE_QUARTERS  = M_W'(17);
   localparam logic [9:0]       FALLBACK_US   = 10'd1000;

   localparam logic [IDX_W-1:0] REG_SF  = 3'd0;
   localparam logic [IDX_W-1:0] REG_BW  = 3'd1;
   localparam logic [IDX_W-1:0] REG_CR  = 3'd2;
   localparam logic [IDX_W-1:0] REG_CRC = 3'd3;
   localparam logic [IDX_W-1:0] REG_HDR = 3'd4;
   localparam logic [IDX_W-1:0] REG_PRE = 3'd5;

   typedef struct packed {
      logic              valid;
      logic [PL_W-1:0]   pl;
      logic [WA_W-1:0]   wa;
      logic [WQ_W-1:0]   wq;
      logic [NA_W-1:0]   na;
      logic [NQ_W-1:0]   nq;
   } cell_data_type;

endpackage

`default_nettype wire

@@ hdl/ltoa_cell.sv @@
// ----------------------------------------------------------------------------
// ltoa_cell
// One restoring-division step for the symbol time and, when enabled, for
// the payload block count. Registered toward the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ltoa_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          advance,
   input  wire                          narrow_en,
   input  wire [ltoa_pkg::BW_W-1:0]     bw,
   input  wire [ltoa_pkg::NA_W-1:0]     den,
   input  ltoa_pkg::cell_data_type      cell_in,
   output ltoa_pkg::cell_data_type      cell_out
);

   ltoa_pkg::cell_data_type         cell_ff;
   ltoa_pkg::cell_data_type         cell_in_next;
   logic [ltoa_pkg::WA_W:0]         wshift;
   logic [ltoa_pkg::NA_W:0]         nshift;

   always_comb begin
      cell_in_next = cell_in;
      wshift = {cell_in.wa, cell_in.wq[ltoa_pkg::WQ_W-1]};
      if (wshift >= {1'b0, bw}) begin
         cell_in_next.wa = ltoa_pkg::WA_W'(wshift - {1'b0, bw});
         cell_in_next.wq = {cell_in.wq[ltoa_pkg::WQ_W-2:0], 1'b1};
      end else begin
         cell_in_next.wa = wshift[ltoa_pkg::WA_W-1:0];
         cell_in_next.wq = {cell_in.wq[ltoa_pkg::WQ_W-2:0], 1'b0};
      end
      nshift = {cell_in.na, cell_in.nq[ltoa_pkg::NQ_W-1]};
      if (narrow_en) begin
         if (nshift >= {1'b0, den}) begin
            cell_in_next.na = ltoa_pkg::NA_W'(nshift - {1'b0, den});
            cell_in_next.nq = {cell_in.nq[ltoa_pkg::NQ_W-2:0], 1'b1};
         end else begin
            cell_in_next.na = nshift[ltoa_pkg::NA_W-1:0];
            cell_in_next.nq = {cell_in.nq[ltoa_pkg::NQ_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff.valid <= cell_in_next.valid;
      end
      if (advance) begin
         cell_ff.pl <= cell_in_next.pl;
         cell_ff.wa <= cell_in_next.wa;
         cell_ff.wq <= cell_in_next.wq;
         cell_ff.na <= cell_in_next.na;
         cell_ff.nq <= cell_in_next.nq;
      end
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

@@ hdl/ltoa_tail.sv @@
// ----------------------------------------------------------------------------
// ltoa_tail
// Symbol count, total multiply, scaling and saturation, or payload bytes times 1000 us in fallback; holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ltoa_tail (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          advance,
   input  wire                          fallback,
   input  wire [ltoa_pkg::CR_W-1:0]     cr,
   input  wire [ltoa_pkg::PRE_W-1:0]    pre,
   input  ltoa_pkg::cell_data_type      cell_in,
   output logic                         rsp_valid,
   output logic [ltoa_pkg::OUT_W-1:0]   rsp_airtime_us,
   output logic                         rsp_saturated
);

   // stage 1: payload symbols
   logic                          s1_valid_ff;
   logic [ltoa_pkg::PL_W-1:0]     s1_pl_ff;
   logic [ltoa_pkg::WQ_W-1:0]     s1_tsym_ff;
   logic [ltoa_pkg::PSYM_W-1:0]   s1_psym_ff;
   logic [ltoa_pkg::PSYM_W-1:0]   s1_psym_in;
   // stage 2: total quarter-symbol count
   logic                          s2_valid_ff;
   logic [ltoa_pkg::PL_W-1:0]     s2_pl_ff;
   logic [ltoa_pkg::WQ_W-1:0]     s2_tsym_ff;
   logic [ltoa_pkg::M_W-1:0]      s2_m_ff;
   logic [ltoa_pkg::M_W-1:0]      s2_m_in;
   // stage 3: product
   logic                          s3_valid_ff;
   logic [ltoa_pkg::PL_W-1:0]     s3_pl_ff;
   logic [ltoa_pkg::PROD_W-1:0]   s3_prod_ff;
   // output
   logic                          out_valid_ff;
   logic [ltoa_pkg::OUT_W-1:0]    out_time_ff;
   logic                          out_sat_ff;
   logic [ltoa_pkg::OUT_W-1:0]    out_time_in;
   logic                          out_sat_in;
   logic [ltoa_pkg::PROD_W-3:0]   total;
   logic [17:0]                   fb_time;

   assign s1_psym_in = ltoa_pkg::PSYM_W'(cell_in.nq) * ltoa_pkg::PSYM_W'({1'b0, cr} + 4'd4)
                       + ltoa_pkg::PSYM_W'(8);
   assign s2_m_in = ({4'b0, pre} << 2) + ltoa_pkg::PRE_QUARTERS
                    + ({4'b0, s1_psym_ff} << 2);
   assign total   = s3_prod_ff[ltoa_pkg::PROD_W-1:2];
   assign fb_time = {10'b0, s3_pl_ff} * {8'b0, ltoa_pkg::FALLBACK_US};

   always_comb begin
      if (fallback) begin
         out_time_in = ltoa_pkg::OUT_W'(fb_time);
         out_sat_in  = 1'b0;
      end else if (|total[ltoa_pkg::PROD_W-3:ltoa_pkg::OUT_W]) begin
         out_time_in = '1;
         out_sat_in  = 1'b1;
      end else begin
         out_time_in = total[ltoa_pkg::OUT_W-1:0];
         out_sat_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cell_in.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s1_pl_ff    <= cell_in.pl;
         s1_tsym_ff  <= cell_in.wq;
         s1_psym_ff  <= s1_psym_in;
         s2_pl_ff    <= s1_pl_ff;
         s2_tsym_ff  <= s1_tsym_ff;
         s2_m_ff     <= s2_m_in;
         s3_pl_ff    <= s2_pl_ff;
         s3_prod_ff  <= s2_tsym_ff * s2_m_ff;
         out_time_ff <= out_time_in;
         out_sat_ff  <= out_sat_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_airtime_us = out_time_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

`default_nettype wire

@@ hdl/lora_time_on_air_unit.sv @@
// ----------------------------------------------------------------------------
// lora_time_on_air_unit
// LoRa packet time on air in microseconds from a payload length.
// ----------------------------------------------------------------------------
//   channel  ports                                   direction
//   req      req_valid req_stall req_payload_bytes   in
//   rsp      rsp_valid rsp_stall rsp_airtime_us      out
//            rsp_saturated
//   csr      csr_write csr_index csr_data            in
//
// One item per cycle while not stalled; 35 division cells (one quotient
// bit of the symbol time each, the last 12 also one bit of the block count)
// then 4 tail stages (symbol count, sum, multiply, saturate).
// The whole pipeline holds while a result waits under rsp_stall.
// Reset loads the default configuration and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lora_time_on_air_unit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire [ltoa_pkg::PL_W-1:0]        req_payload_bytes,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic [ltoa_pkg::OUT_W-1:0]      rsp_airtime_us,
   output logic                            rsp_saturated,
   input  wire                             csr_write,
   input  wire [ltoa_pkg::IDX_W-1:0]       csr_index,
   input  wire [ltoa_pkg::DATA_W-1:0]      csr_data
);

   logic [ltoa_pkg::SF_W-1:0]   sf_ff;
   logic [ltoa_pkg::BW_W-1:0]   bw_ff;
   logic [ltoa_pkg::CR_W-1:0]   cr_ff;
   logic                        crc_ff;
   logic                        hdr_ff;
   logic [ltoa_pkg::PRE_W-1:0]  pre_ff;

   logic                        advance;
   logic                        fallback;
   logic                        ldro;
   logic [4:0]                  sf_eff;
   logic [ltoa_pkg::NA_W-1:0]   den;
   logic [13:0]                 num;
   logic [12:0]                 num_pos;
   logic [12:0]                 nceil;
   ltoa_pkg::cell_data_type     head;
   ltoa_pkg::cell_data_type     chain [ltoa_pkg::NCELLS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff  <= ltoa_pkg::SF_W'(7);
         bw_ff  <= ltoa_pkg::BW_W'(125000);
         cr_ff  <= ltoa_pkg::CR_W'(1);
         crc_ff <= 1'b1;
         hdr_ff <= 1'b1;
         pre_ff <= ltoa_pkg::PRE_W'(8);
      end else if (csr_write) begin
         unique case (csr_index)
            ltoa_pkg::REG_SF:  sf_ff  <= csr_data[ltoa_pkg::SF_W-1:0];
            ltoa_pkg::REG_BW:  bw_ff  <= csr_data[ltoa_pkg::BW_W-1:0];
            ltoa_pkg::REG_CR:  cr_ff  <= csr_data[ltoa_pkg::CR_W-1:0];
            ltoa_pkg::REG_CRC: crc_ff <= csr_data[0];
            ltoa_pkg::REG_HDR: hdr_ff <= csr_data[0];
            ltoa_pkg::REG_PRE: pre_ff <= csr_data[ltoa_pkg::PRE_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign fallback  = (sf_ff == '0) || (bw_ff == '0);
   assign ldro      = (sf_ff >= ltoa_pkg::LDRO_SF_MIN) && (bw_ff <= ltoa_pkg::LDRO_BW_LIMIT);
   assign sf_eff    = {1'b0, sf_ff} - (ldro ? 5'd2 : 5'd0);

   always_comb begin
      den = {sf_eff[3:0], 2'b00};
      if (sf_eff[4] || den == '0) begin
         den = ltoa_pkg::NA_W'(1);
      end
      num = {3'b0, req_payload_bytes, 3'b0} - {8'b0, sf_ff, 2'b0}
            + ltoa_pkg::NUM_OFFSET
            + (crc_ff ? ltoa_pkg::CRC_BITS : 14'd0)
            - (hdr_ff ? 14'd0 : ltoa_pkg::IMPL_PENALTY);
      num_pos = num[13] ? 13'd0 : num[12:0];
      nceil   = num_pos + {7'b0, den} - 13'd1;

      head.valid = req_valid;
      head.pl    = req_payload_bytes;
      head.wa    = '0;
      head.wq    = ltoa_pkg::US_PER_SECOND << sf_ff;
      head.na    = '0;
      head.nq    = nceil[ltoa_pkg::NQ_W-1:0];
   end

   assign chain[0] = head;

   for (genvar i = 0; i < ltoa_pkg::NCELLS; i++) begin : g_cell
      ltoa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .narrow_en (i >= (ltoa_pkg::NCELLS - ltoa_pkg::NQ_W)),
         .bw        (bw_ff),
         .den       (den),
         .cell_in   (chain[i]),
         .cell_out  (chain[i+1])
      );
   end

   ltoa_tail u_tail (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .fallback       (fallback),
      .cr             (cr_ff),
      .pre            (pre_ff),
      .cell_in        (chain[ltoa_pkg::NCELLS]),
      .rsp_valid      (rsp_valid),
      .rsp_airtime_us (rsp_airtime_us),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

`default_nettype wire
